// ===== src/tlvd_pkg.sv =====
// ----------------------------------------------------------------------------
// tlvd_pkg
// Shared constants for the TLV list deframer.
// ----------------------------------------------------------------------------
package tlvd_pkg;

    localparam int unsigned TLV_HDR_BYTES     = 4;
    localparam int unsigned TLV_LEN_W         = 16;
    localparam int unsigned TLV_IDX_W         = 14;
    localparam int unsigned TLV_LEN_HI_POS    = 2;
    localparam int unsigned TLV_LEN_LO_POS    = 3;

endpackage

// ===== src/tlv_list_deframer.sv =====
// ----------------------------------------------------------------------------
// tlv_list_deframer
// Splits a TLV list arriving one byte per request and tags each byte with its
// TLV number, offset, padding and end-of-TLV marks; rejects bad headers.
// ----------------------------------------------------------------------------
//  channel | handshake            | payload
//  --------+----------------------+--------------------------------------------
//  in      | in_valid / in_ready  | list_byte, list_start, list_length
//  out     | out_valid / out_ready| out_byte, tlv_index, byte_in_tlv,
//          |                      | is_padding, tlv_last, list_fail
//
//  One input request per cycle while in_ready is high; each gives zero or one result, in the next cycle.
//  The result register sets the rate: in_ready is high while it is empty or
//  being drained in the same cycle.
//  rst_n clears the parse state and leaves the block idle until list_start.
//  A stall on out holds the result register and back-pressures in.
// ----------------------------------------------------------------------------
module tlv_list_deframer
    import tlvd_pkg::*;
#(
    parameter int unsigned LEN_BITS = 16
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic [7:0]           list_byte,
    input  logic                 list_start,
    input  logic [TLV_LEN_W-1:0] list_length,
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic [7:0]           out_byte,
    output logic [TLV_IDX_W-1:0] tlv_index,
    output logic [TLV_LEN_W-1:0] byte_in_tlv,
    output logic                 is_padding,
    output logic                 tlv_last,
    output logic                 list_fail
);

    localparam int unsigned REM_W = (LEN_BITS < TLV_LEN_W) ? LEN_BITS : TLV_LEN_W;
    localparam int unsigned CMP_W = TLV_LEN_W + 2;

    logic [REM_W-1:0]     remaining_reg, remaining_next;
    logic [TLV_LEN_W-1:0] pos_reg, pos_next;
    logic [TLV_LEN_W-1:0] decl_reg, decl_next;
    logic [TLV_IDX_W-1:0] cnt_reg, cnt_next;
    logic [7:0]           hi_reg, hi_next;
    logic                 stopped_reg, stopped_next;

    logic                 out_valid_reg, out_valid_next;
    logic [7:0]           out_byte_reg, out_byte_next;
    logic [TLV_IDX_W-1:0] tlv_index_reg, tlv_index_next;
    logic [TLV_LEN_W-1:0] byte_in_tlv_reg, byte_in_tlv_next;
    logic                 is_padding_reg, is_padding_next;
    logic                 tlv_last_reg, tlv_last_next;
    logic                 list_fail_reg, list_fail_next;

    logic                 accept;
    logic [REM_W-1:0]     rem_eff;
    logic [TLV_LEN_W-1:0] pos_eff;
    logic [TLV_LEN_W-1:0] decl_eff;
    logic [TLV_IDX_W-1:0] cnt_eff;
    logic [7:0]           hi_eff;
    logic                 stop_eff;
    logic [TLV_LEN_W-1:0] hdr_len;
    logic [CMP_W-1:0]     rem_plus3;
    logic                 bad_hdr;
    logic [TLV_LEN_W:0]   total;
    logic                 pad;
    logic                 last;

    assign in_ready = !out_valid_reg || out_ready;
    assign accept   = in_valid && in_ready;

    always_comb
    begin
        rem_eff  = list_start ? list_length[REM_W-1:0] : remaining_reg;
        pos_eff  = list_start ? '0 : pos_reg;
        decl_eff = list_start ? '0 : decl_reg;
        cnt_eff  = list_start ? '0 : cnt_reg;
        hi_eff   = list_start ? '0 : hi_reg;
        stop_eff = list_start ? 1'b0 : stopped_reg;

        hdr_len   = {hi_eff, list_byte};
        rem_plus3 = CMP_W'(rem_eff) + CMP_W'(3);
        bad_hdr   = (hdr_len < TLV_LEN_W'(TLV_HDR_BYTES))
                    || (CMP_W'(hdr_len) > rem_plus3);

        remaining_next = rem_eff;
        pos_next       = pos_eff;
        decl_next      = decl_eff;
        cnt_next       = cnt_eff;
        hi_next        = hi_eff;
        stopped_next   = stop_eff;

        out_valid_next   = out_valid_reg && !out_ready;
        out_byte_next    = out_byte_reg;
        tlv_index_next   = tlv_index_reg;
        byte_in_tlv_next = byte_in_tlv_reg;
        is_padding_next  = is_padding_reg;
        tlv_last_next    = tlv_last_reg;
        list_fail_next   = list_fail_reg;

        if (pos_eff == TLV_LEN_W'(TLV_LEN_HI_POS))
        begin
            hi_next = list_byte;
        end
        if (pos_eff == TLV_LEN_W'(TLV_LEN_LO_POS))
        begin
            decl_next = hdr_len;
        end

        total = (TLV_LEN_W'(0) + {1'b0, decl_next} + (TLV_LEN_W + 1)'(3))
                & ~(TLV_LEN_W + 1)'(3);
        pad   = (pos_eff >= TLV_LEN_W'(TLV_HDR_BYTES)) && (pos_eff >= decl_next);
        last  = (pos_eff >= TLV_LEN_W'(TLV_LEN_LO_POS))
                && (({1'b0, pos_eff} + (TLV_LEN_W + 1)'(1) == total)
                    || (rem_eff == REM_W'(1)));

        if (!accept)
        begin
            remaining_next = remaining_reg;
            pos_next       = pos_reg;
            decl_next      = decl_reg;
            cnt_next       = cnt_reg;
            hi_next        = hi_reg;
            stopped_next   = stopped_reg;
        end
        else if (stop_eff)
        begin
            hi_next   = hi_eff;
            decl_next = decl_eff;
        end
        else if ((rem_eff == '0)
                 || ((pos_eff == '0) && (rem_eff < REM_W'(TLV_HDR_BYTES))))
        begin
            hi_next      = hi_eff;
            decl_next    = decl_eff;
            stopped_next = 1'b1;
        end
        else if ((pos_eff == TLV_LEN_W'(TLV_LEN_LO_POS)) && bad_hdr)
        begin
            decl_next        = decl_eff;
            stopped_next     = 1'b1;
            out_valid_next   = 1'b1;
            out_byte_next    = list_byte;
            tlv_index_next   = cnt_eff;
            byte_in_tlv_next = TLV_LEN_W'(TLV_LEN_LO_POS);
            is_padding_next  = 1'b0;
            tlv_last_next    = 1'b0;
            list_fail_next   = 1'b1;
        end
        else
        begin
            out_valid_next   = 1'b1;
            out_byte_next    = pad ? 8'h00 : list_byte;
            tlv_index_next   = cnt_eff;
            byte_in_tlv_next = pos_eff;
            is_padding_next  = pad;
            tlv_last_next    = last;
            list_fail_next   = 1'b0;
            remaining_next   = rem_eff - REM_W'(1);
            if (last)
            begin
                pos_next = '0;
                cnt_next = cnt_eff + TLV_IDX_W'(1);
            end
            else
            begin
                pos_next = pos_eff + TLV_LEN_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            remaining_reg <= '0;
            pos_reg       <= '0;
            decl_reg      <= '0;
            cnt_reg       <= '0;
            hi_reg        <= '0;
            stopped_reg   <= 1'b1;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            remaining_reg <= remaining_next;
            pos_reg       <= pos_next;
            decl_reg      <= decl_next;
            cnt_reg       <= cnt_next;
            hi_reg        <= hi_next;
            stopped_reg   <= stopped_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_byte_reg    <= out_byte_next;
        tlv_index_reg   <= tlv_index_next;
        byte_in_tlv_reg <= byte_in_tlv_next;
        is_padding_reg  <= is_padding_next;
        tlv_last_reg    <= tlv_last_next;
        list_fail_reg   <= list_fail_next;
    end

    assign out_valid   = out_valid_reg;
    assign out_byte    = out_byte_reg;
    assign tlv_index   = tlv_index_reg;
    assign byte_in_tlv = byte_in_tlv_reg;
    assign is_padding  = is_padding_reg;
    assign tlv_last    = tlv_last_reg;
    assign list_fail   = list_fail_reg;

endmodule

// ===== bench/tb_tlv_list_deframer.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_tlv_list_deframer
// Self-checking bench for the TLV list deframer. Feeds valid, truncated and
// corrupted TLV lists, restarts and stray bytes under random idling and one
// long output hold-off. Predicts each byte's tags and compares every result.
// ----------------------------------------------------------------------------
module tb_tlv_list_deframer;
    import tlvd_pkg::*;

    localparam int unsigned STALL_LIMIT = 4000;
    localparam int unsigned ITEM_TARGET = 1850;
    localparam int unsigned HOLD_CYCLES = 400;

    typedef struct packed {
        logic [7:0]           data;
        logic [TLV_IDX_W-1:0] idx;
        logic [TLV_LEN_W-1:0] offs;
        logic                 pad;
        logic                 last;
        logic                 fail;
    } byte_tag_t;

    class tlv_tag_scoreboard;
        logic [17:0]          left_bytes;
        logic [TLV_LEN_W-1:0] offset_next;
        logic [TLV_LEN_W-1:0] tlv_len;
        logic [TLV_IDX_W-1:0] tlv_num;
        logic [7:0]           len_hi;
        bit                   halted;
        byte_tag_t            pending_tags[$];
        int                   errors;

        function new();
            left_bytes  = '0;
            offset_next = '0;
            tlv_len     = '0;
            tlv_num     = '0;
            len_hi      = '0;
            halted      = 1'b1;
            errors      = 0;
        endfunction

        function void note_request(logic [7:0] b, logic s, logic [TLV_LEN_W-1:0] l);
            byte_tag_t   t;
            int unsigned hdr_len;
            int unsigned padded;
            int unsigned pos;
            bit          pad;
            bit          last;
            if (s)
            begin
                left_bytes  = {2'b00, l};
                offset_next = '0;
                tlv_len     = '0;
                tlv_num     = '0;
                len_hi      = '0;
                halted      = 1'b0;
            end
            if (halted)
                return;
            if (left_bytes == 0 || (offset_next == 0 && left_bytes < TLV_HDR_BYTES))
            begin
                halted = 1'b1;
                return;
            end
            pos = offset_next;
            t   = '0;
            if (pos == TLV_LEN_HI_POS)
                len_hi = b;
            if (pos == TLV_LEN_LO_POS)
            begin
                hdr_len = {len_hi, b};
                if (hdr_len < TLV_HDR_BYTES || hdr_len > left_bytes + 3)
                begin
                    t.data = b;
                    t.idx  = tlv_num;
                    t.offs = TLV_LEN_W'(TLV_LEN_LO_POS);
                    t.fail = 1'b1;
                    pending_tags.push_back(t);
                    halted = 1'b1;
                    return;
                end
                tlv_len = hdr_len[TLV_LEN_W-1:0];
            end
            padded = (int'(tlv_len) + 3) & ~32'd3;
            pad    = pos >= TLV_HDR_BYTES && pos >= tlv_len;
            last   = pos >= TLV_LEN_LO_POS && (pos + 1 == padded || left_bytes == 1);
            t.data = pad ? 8'h00 : b;
            t.idx  = tlv_num;
            t.offs = pos[TLV_LEN_W-1:0];
            t.pad  = pad;
            t.last = last;
            pending_tags.push_back(t);
            left_bytes = left_bytes - 18'd1;
            if (last)
            begin
                offset_next = '0;
                tlv_num     = tlv_num + TLV_IDX_W'(1);
            end
            else
                offset_next = offset_next + TLV_LEN_W'(1);
        endfunction

        function void compare_field(string field, int unsigned want, int unsigned got);
            if (want != got)
            begin
                errors++;
                $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h",
                         $time, field, want, got);
            end
        endfunction

        function void check_tag(byte_tag_t got);
            byte_tag_t want;
            if (pending_tags.size() == 0)
            begin
                errors++;
                $display("%0t: unexpected result, expected none, %s 0x%0h tlv %0d offset %0d",
                         $time, "actual byte", got.data, got.idx, got.offs);
                return;
            end
            want = pending_tags.pop_front();
            compare_field("out_byte", want.data, got.data);
            compare_field("tlv_index", want.idx, got.idx);
            compare_field("byte_in_tlv", want.offs, got.offs);
            compare_field("is_padding", want.pad, got.pad);
            compare_field("tlv_last", want.last, got.last);
            compare_field("list_fail", want.fail, got.fail);
        endfunction
    endclass

    logic                 clk;
    logic                 rst_n;
    logic                 in_valid;
    logic                 in_ready;
    logic [7:0]           list_byte;
    logic                 list_start;
    logic [TLV_LEN_W-1:0] list_length;
    logic                 out_valid;
    logic                 out_ready;
    logic [7:0]           out_byte;
    logic [TLV_IDX_W-1:0] tlv_index;
    logic [TLV_LEN_W-1:0] byte_in_tlv;
    logic                 is_padding;
    logic                 tlv_last;
    logic                 list_fail;

    tlv_tag_scoreboard tag_board;
    int unsigned       sent_bytes;
    int unsigned       send_idle_pct;
    int unsigned       stall_pct;
    bit                hold_req;
    int unsigned       quiet_cycles = 0;

    tlv_list_deframer u_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .list_byte   (list_byte),
        .list_start  (list_start),
        .list_length (list_length),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .out_byte    (out_byte),
        .tlv_index   (tlv_index),
        .byte_in_tlv (byte_in_tlv),
        .is_padding  (is_padding),
        .tlv_last    (tlv_last),
        .list_fail   (list_fail)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    task automatic push_byte(input logic [7:0] b, input logic s, input logic [TLV_LEN_W-1:0] l);
        while ($urandom_range(99) < send_idle_pct)
        begin
            @(negedge clk);
            in_valid = 1'b0;
        end
        @(negedge clk);
        in_valid    = 1'b1;
        list_byte   = b;
        list_start  = s;
        list_length = l;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        tag_board.note_request(b, s, l);
        sent_bytes++;
    endtask

    task automatic send_list(input logic [7:0] stream_in[$],
                             input logic [TLV_LEN_W-1:0] len_field);
        foreach (stream_in[i])
            push_byte(stream_in[i], i == 0, (i == 0) ? len_field : TLV_LEN_W'($urandom));
    endtask

    function automatic void add_tlv(ref logic [7:0] q[$], input int unsigned decl,
                                    input int unsigned stored);
        int unsigned padded;
        padded = (decl + 3) / 4 * 4;
        q.push_back(8'($urandom));
        q.push_back(8'($urandom));
        q.push_back(stored[15:8]);
        q.push_back(stored[7:0]);
        for (int unsigned k = TLV_HDR_BYTES; k < padded; k++)
            q.push_back(8'($urandom));
    endfunction

    // receiver: random stalls, plus one long hold-off on request
    initial
    begin
        int unsigned hold_left;
        bit          hold_taken;
        hold_left  = 0;
        hold_taken = 1'b0;
        out_ready  = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_req && !hold_taken)
            begin
                hold_taken = 1'b1;
                hold_left  = HOLD_CYCLES;
            end
            if (hold_left != 0)
            begin
                out_ready = 1'b0;
                hold_left--;
            end
            else
                out_ready = ($urandom_range(99) >= stall_pct);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid === 1'b1 && out_ready)
            tag_board.check_tag({out_byte, tlv_index, byte_in_tlv, is_padding, tlv_last,
                                 list_fail});
    end

    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("Regression FAIL");
            $finish;
        end
    end

    initial
    begin
        logic [7:0]           stream[$];
        logic [TLV_LEN_W-1:0] len_field;
        int unsigned          decl;
        int unsigned          stored;
        int unsigned          cut;
        int unsigned          pick;
        int unsigned          variant;
        int unsigned          n_tlv;
        int unsigned          list_count;
        bit                   hold_done;

        tag_board     = new();
        rst_n         = 1'b0;
        in_valid      = 1'b0;
        list_byte     = '0;
        list_start    = 1'b0;
        list_length   = '0;
        sent_bytes    = 0;
        send_idle_pct = 0;
        stall_pct     = 0;
        hold_req      = 1'b0;
        list_count    = 0;
        hold_done     = 1'b0;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // stray byte while idle
        push_byte(8'hFF, 1'b0, 16'hFFFF);
        // list ends inside padding
        stream.delete();
        add_tlv(stream, 5, 5);
        stream = stream[0:5];
        send_list(stream, 16'd6);
        // byte past the end of the list
        push_byte(8'h00, 1'b0, 16'h0000);
        // short tail after one TLV
        stream.delete();
        add_tlv(stream, 4, 4);
        stream.push_back(8'h5A);
        send_list(stream, 16'd5);
        // restart in the middle of a list
        stream.delete();
        add_tlv(stream, 8, 8);
        stream = stream[0:2];
        send_list(stream, 16'hFFFF);
        // header length below header size
        stream.delete();
        add_tlv(stream, 4, 3);
        send_list(stream, 16'd8);
        // header length beyond the list
        stream.delete();
        add_tlv(stream, 4, 16'hFFFF);
        send_list(stream, 16'd8);
        // empty list
        push_byte(8'hA5, 1'b1, 16'h0000);

        while (sent_bytes < ITEM_TARGET)
        begin
            case ((list_count / 6) % 4)
                0:
                begin
                    send_idle_pct = 0;
                    stall_pct     = 0;
                end
                1:
                begin
                    send_idle_pct = 51;
                    stall_pct     = 0;
                end
                2:
                begin
                    send_idle_pct = 0;
                    stall_pct     = 51;
                end
                default:
                begin
                    send_idle_pct = 9;
                    stall_pct     = 9;
                end
            endcase
            list_count++;
            pick = $urandom_range(99);
            if (pick < 70)
            begin
                if (!hold_done && sent_bytes >= 700)
                begin
                    hold_done     = 1'b1;
                    send_idle_pct = 0;
                    hold_req      = 1'b1;
                end
                stream.delete();
                n_tlv = $urandom_range(1, 5);
                repeat (n_tlv)
                begin
                    decl = ($urandom_range(99) == 0) ? $urandom_range(256, 520)
                                                     : $urandom_range(4, 20);
                    stored = decl;
                    if ($urandom_range(19) == 0)
                        stored = $urandom_range(1) ? $urandom_range(3) : $urandom_range(65535);
                    add_tlv(stream, decl, stored);
                end
                len_field = TLV_LEN_W'(stream.size());
                variant   = $urandom_range(9);
                if (variant == 6 || variant == 7)
                begin
                    cut       = $urandom_range(1, 3);
                    len_field = len_field - TLV_LEN_W'(cut);
                    stream    = stream[0:stream.size() - 1 - cut];
                end
                else if (variant == 8)
                begin
                    cut       = $urandom_range(1, 3);
                    len_field = len_field + TLV_LEN_W'(cut);
                    repeat (cut) stream.push_back(8'($urandom));
                end
                else if (variant == 9)
                    stream = stream[0:$urandom_range(0, stream.size() - 1)];
                if ($urandom_range(2) == 0)
                    repeat ($urandom_range(1, 2)) stream.push_back(8'($urandom));
                send_list(stream, len_field);
            end
            else if (pick < 85)
            begin
                repeat ($urandom_range(1, 4))
                    push_byte(8'($urandom), 1'b0, TLV_LEN_W'($urandom));
            end
            else
            begin
                stream.delete();
                repeat ($urandom_range(1, 6)) stream.push_back(8'($urandom));
                send_list(stream, TLV_LEN_W'($urandom));
            end
        end

        @(negedge clk);
        in_valid = 1'b0;
        while (tag_board.pending_tags.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
        if (tag_board.errors == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
